// ===== rtl/grid_node_jacobian_metrics_macros.svh =====
// Assertion macros used by the checker of the grid node metrics block.
`ifndef GRID_NODE_JACOBIAN_METRICS_MACROS_SVH
`define GRID_NODE_JACOBIAN_METRICS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GNJM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gnjm: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GNJM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gnjm: next-cycle check failed");

`endif

// ===== rtl/gnjm_pkg.sv =====
// Types, widths and constants of the grid node metrics pipeline.
package gnjm_pkg;

    localparam int DIMS_DEFAULT = 3;
    localparam int FRAC_DEFAULT = 16;

    localparam int DIFF_W     = 32;
    localparam int NUM_DIFF   = 9;
    localparam int COF_W      = 64;
    localparam int DET_W      = 98;
    localparam int JAC_W      = 64;
    localparam int JAC_FRAC   = 32;
    localparam int INV_W      = 32;
    localparam int QBITS      = 34;
    localparam int DIV_STEPS  = QBITS;

    localparam int IN_DATA_W  = NUM_DIFF * DIFF_W;
    localparam int OUT_DATA_W = JAC_W + NUM_DIFF * INV_W;

    localparam logic [INV_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [INV_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [DET_W-1:0] r;
        logic [QBITS-1:0] low;
        logic [QBITS-1:0] q;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [NUM_DIFF-1:0] lane;
        logic [DET_W-1:0]         ud;
        logic [JAC_W-1:0]         jac;
        logic                     zero;
    } div_state_t;

endpackage

// ===== rtl/gnjm_front.sv =====
// Input register, cofactor products and determinant stages.
module gnjm_front
    import gnjm_pkg::*;
#(
    parameter int NUM_DIMS = DIMS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [IN_DATA_W-1:0]         tdata,
    output logic signed [DET_W-1:0]      det,
    output logic [NUM_DIFF-1:0][COF_W-1:0] cof
);

    localparam int NDIM = (NUM_DIMS == 2) ? 2 : 3;

    logic signed [DIFF_W-1:0] d0_reg [NUM_DIFF];
    logic signed [DIFF_W-1:0] d1_reg [NUM_DIFF];
    logic signed [COF_W-1:0]  pa_reg [NUM_DIFF];
    logic signed [COF_W-1:0]  pb_reg [NUM_DIFF];
    logic signed [COF_W-1:0]  pa_next [NUM_DIFF];
    logic signed [COF_W-1:0]  pb_next [NUM_DIFF];
    logic signed [DIFF_W-1:0] r2_reg [3];
    logic signed [COF_W-1:0]  cof2_reg [NUM_DIFF];
    logic signed [COF_W-1:0]  cof2_next [NUM_DIFF];
    logic signed [COF_W-1:0]  cof3_reg [NUM_DIFF];
    logic signed [COF_W-1:0]  pl_reg [3];
    logic signed [COF_W-1:0]  ph_reg [3];
    logic signed [COF_W-1:0]  pl_next [3];
    logic signed [COF_W-1:0]  ph_next [3];
    logic signed [DET_W-1:0]  det_reg;
    logic signed [DET_W-1:0]  det_next;
    logic [NUM_DIFF-1:0][COF_W-1:0] cof4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pa_next[i*3+j] = d0_reg[((i+1)%3)*3 + (j+1)%3]
                               * d0_reg[((i+2)%3)*3 + (j+2)%3];
                pb_next[i*3+j] = d0_reg[((i+1)%3)*3 + (j+2)%3]
                               * d0_reg[((i+2)%3)*3 + (j+1)%3];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_DIFF; k++)
        begin
            cof2_next[k] = '0;
        end
        if (NDIM == 2)
        begin
            cof2_next[0] = COF_W'(d1_reg[4]);
            cof2_next[1] = COF_W'(0) - COF_W'(d1_reg[3]);
            cof2_next[3] = COF_W'(0) - COF_W'(d1_reg[1]);
            cof2_next[4] = COF_W'(d1_reg[0]);
        end
        else
        begin
            for (int k = 0; k < NUM_DIFF; k++)
            begin
                cof2_next[k] = pa_reg[k] - pb_reg[k];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            pl_next[j] = COF_W'(r2_reg[j]) * $signed({1'b0, cof2_reg[j][31:0]});
            ph_next[j] = COF_W'(r2_reg[j]) * COF_W'($signed(cof2_reg[j][63:32]));
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DET_W'(ph_reg[j]) <<< 32) + DET_W'(pl_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_DIFF; k++)
            begin
                d0_reg[k]   <= tdata[k*DIFF_W +: DIFF_W];
                d1_reg[k]   <= d0_reg[k];
                pa_reg[k]   <= pa_next[k];
                pb_reg[k]   <= pb_next[k];
                cof2_reg[k] <= cof2_next[k];
                cof3_reg[k] <= cof2_reg[k];
                cof4_reg[k] <= cof3_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                r2_reg[j] <= d1_reg[j];
                pl_reg[j] <= pl_next[j];
                ph_reg[j] <= ph_next[j];
            end
            det_reg <= det_next;
        end
    end

    assign det = det_reg;
    assign cof = cof4_reg;

endmodule

// ===== rtl/gnjm_prep.sv =====
// Jacobian rounding and divider setup stages.
module gnjm_prep
    import gnjm_pkg::*;
#(
    parameter int NUM_DIMS  = DIMS_DEFAULT,
    parameter int FRAC_BITS = FRAC_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [DET_W-1:0]        det,
    input  logic [NUM_DIFF-1:0][COF_W-1:0] cof,
    output div_state_t                     st
);

    localparam int NDIM   = (NUM_DIMS == 2) ? 2 : 3;
    localparam int JS     = NDIM * FRAC_BITS + NDIM - JAC_FRAC;
    localparam int JSR    = (JS > 0) ? JS : 0;
    localparam int JSL    = (JS < 0) ? -JS : 0;
    localparam int RND_SH = (JS > 0) ? JS - 1 : 0;
    localparam int JW     = DET_W + 16;
    localparam int NW     = COF_W + 2 * FRAC_BITS + 2;

    logic [DET_W-1:0]              ud_reg, ud_next;
    logic [JAC_W-1:0]              jac_reg, jac_next;
    logic                          zero_reg;
    logic [COF_W-1:0]              acof_reg [NUM_DIFF];
    logic [COF_W-1:0]              acof_next [NUM_DIFF];
    logic                          neg_reg [NUM_DIFF];
    logic signed [JW-1:0]          t_ext;
    logic signed [JW-1:0]          rnd;
    logic [NW-1:0]                 num2 [NUM_DIFF];
    div_state_t                    st_reg, st_next;

    always_comb
    begin
        ud_next = det[DET_W-1] ? (DET_W'(0) - det) : det;
        rnd     = (JSR > 0) ? (JW'(1) <<< RND_SH) : JW'(0);
        t_ext   = ((JW'(det) + rnd) >>> JSR) <<< JSL;
        if ((t_ext[JW-1:JAC_W-1] == '0) || (t_ext[JW-1:JAC_W-1] == '1))
        begin
            jac_next = t_ext[JAC_W-1:0];
        end
        else if (t_ext[JW-1])
        begin
            jac_next = {1'b1, {(JAC_W-1){1'b0}}};
        end
        else
        begin
            jac_next = {1'b0, {(JAC_W-1){1'b1}}};
        end
        for (int k = 0; k < NUM_DIFF; k++)
        begin
            acof_next[k] = cof[k][COF_W-1] ? (COF_W'(0) - cof[k]) : cof[k];
        end
    end

    always_comb
    begin
        st_next.ud   = ud_reg;
        st_next.jac  = jac_reg;
        st_next.zero = zero_reg;
        for (int k = 0; k < NUM_DIFF; k++)
        begin
            num2[k]             = {acof_reg[k], {(2*FRAC_BITS+2){1'b0}}};
            st_next.lane[k].r   = DET_W'(num2[k][NW-1:QBITS]);
            st_next.lane[k].low = num2[k][QBITS-1:0];
            st_next.lane[k].q   = '0;
            st_next.lane[k].neg = neg_reg[k];
            st_next.lane[k].ovf = (DET_W'(num2[k][NW-1:QBITS]) >= ud_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ud_reg   <= ud_next;
            jac_reg  <= jac_next;
            zero_reg <= (det == '0);
            for (int k = 0; k < NUM_DIFF; k++)
            begin
                acof_reg[k] <= acof_next[k];
                neg_reg[k]  <= cof[k][COF_W-1] ^ det[DET_W-1];
            end
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

endmodule

// ===== rtl/gnjm_div_step.sv =====
// One restoring division step for all inverse entries.
module gnjm_div_step
    import gnjm_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  div_state_t din,
    output div_state_t dout
);

    div_state_t             dout_reg, dout_next;
    logic [DET_W:0]         trial [NUM_DIFF];
    logic                   ge [NUM_DIFF];

    always_comb
    begin
        dout_next = din;
        for (int k = 0; k < NUM_DIFF; k++)
        begin
            trial[k] = {din.lane[k].r, din.lane[k].low[QBITS-1]};
            ge[k]    = (trial[k] >= {1'b0, din.ud});
            dout_next.lane[k].r   = ge[k] ? DET_W'(trial[k] - {1'b0, din.ud})
                                          : trial[k][DET_W-1:0];
            dout_next.lane[k].low = {din.lane[k].low[QBITS-2:0], 1'b0};
            dout_next.lane[k].q   = {din.lane[k].q[QBITS-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/gnjm_post.sv =====
// Rounding, saturation, masking of the unused 2-D entries, and output register.
module gnjm_post
    import gnjm_pkg::*;
#(
    parameter int NUM_DIMS = DIMS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  en,
    input  div_state_t            din,
    output logic [OUT_DATA_W-1:0] tdata,
    output logic                  tuser
);

    localparam int NDIM = (NUM_DIMS == 2) ? 2 : 3;

    logic [OUT_DATA_W-1:0] tdata_reg, tdata_next;
    logic                  tuser_reg;
    logic [QBITS:0]        qsum [NUM_DIFF];
    logic [QBITS-1:0]      qr [NUM_DIFF];
    logic [QBITS-1:0]      lim [NUM_DIFF];
    logic [INV_W-1:0]      val [NUM_DIFF];

    always_comb
    begin
        tdata_next[JAC_W-1:0] = din.jac;
        for (int k = 0; k < NUM_DIFF; k++)
        begin
            qsum[k] = {1'b0, din.lane[k].q} + (QBITS+1)'(1);
            qr[k]   = qsum[k][QBITS:1];
            lim[k]  = din.lane[k].neg ? QBITS'(SAT_NEG) : QBITS'(SAT_POS);
            if (din.lane[k].ovf || (qr[k] > lim[k]))
            begin
                val[k] = din.lane[k].neg ? SAT_NEG : SAT_POS;
            end
            else
            begin
                val[k] = din.lane[k].neg ? (INV_W'(0) - qr[k][INV_W-1:0])
                                         : qr[k][INV_W-1:0];
            end
            if ((NDIM == 2) && (((k / 3) == 2) || ((k % 3) == 2)))
            begin
                val[k] = '0;
            end
            tdata_next[JAC_W + k*INV_W +: INV_W] = val[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= din.zero;
        end
    end

    assign tdata = tdata_reg;
    assign tuser = tuser_reg;

endmodule

// ===== rtl/grid_node_jacobian_metrics.sv =====
// Throughput: one request per cycle while the output is not stalled; the 34 divider steps are fully pipelined.
// The whole pipeline advances together while the output register is empty or taken.
// Reset: rst_n asynchronous, active low, clears the stage valid bits only.
// Top level of the grid node Jacobian and inverse metric pipeline.
module grid_node_jacobian_metrics
    import gnjm_pkg::*;
#(
    parameter int NUM_DIMS  = DIMS_DEFAULT,
    parameter int FRAC_BITS = FRAC_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // diff_dir0_coord0, diff_dir0_coord1, diff_dir0_coord2, diff_dir1_coord0,
    // diff_dir1_coord1, diff_dir1_coord2, diff_dir2_coord0, diff_dir2_coord1,
    // diff_dir2_coord2
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // jacobian, inv_r0_c0, inv_r0_c1, inv_r0_c2, inv_r1_c0, inv_r1_c1,
    // inv_r1_c2, inv_r2_c0, inv_r2_c1, inv_r2_c2
    output logic [OUT_DATA_W-1:0] m_tdata,
    // zero_volume
    output logic                  m_tuser
);

    localparam int NST = 5 + 2 + DIV_STEPS + 1;

    logic                          en;
    logic [NST-1:0]                valid_reg, valid_next;
    logic signed [DET_W-1:0]       det;
    logic [NUM_DIFF-1:0][COF_W-1:0] cof;
    div_state_t                    dstate [DIV_STEPS+1];

    assign en       = !valid_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[NST-1];

    always_comb
    begin
        valid_next = en ? {valid_reg[NST-2:0], s_tvalid} : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    gnjm_front #(
        .NUM_DIMS (NUM_DIMS)
    ) u_front (
        .clk   (clk),
        .en    (en),
        .tdata (s_tdata),
        .det   (det),
        .cof   (cof)
    );

    gnjm_prep #(
        .NUM_DIMS  (NUM_DIMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk (clk),
        .en  (en),
        .det (det),
        .cof (cof),
        .st  (dstate[0])
    );

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        gnjm_div_step u_step (
            .clk  (clk),
            .en   (en),
            .din  (dstate[s]),
            .dout (dstate[s+1])
        );
    end

    gnjm_post #(
        .NUM_DIMS (NUM_DIMS)
    ) u_post (
        .clk   (clk),
        .en    (en),
        .din   (dstate[DIV_STEPS]),
        .tdata (m_tdata),
        .tuser (m_tuser)
    );

endmodule

// ===== rtl/gnjm_checker.sv =====
// Port-level checker for the grid node metrics block and its bind.
`include "grid_node_jacobian_metrics_macros.svh"

module gnjm_checker
    import gnjm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    logic [INV_W-1:0] inv00;

    assign inv00 = m_tdata[JAC_W +: INV_W];

    `GNJM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `GNJM_ASSERT_IMPL(a_ready_when_empty, !m_tvalid, s_tready)
    `GNJM_ASSERT_IMPL(a_no_take_on_stall, m_tvalid && !m_tready, !(s_tvalid && s_tready))
    `GNJM_ASSERT_IMPL(a_zero_jac, m_tvalid && m_tuser, m_tdata[63:0] == 64'd0)
    `GNJM_ASSERT_IMPL(a_zero_sat, m_tvalid && m_tuser, (inv00 == SAT_POS) || (inv00 == SAT_NEG))

endmodule

bind grid_node_jacobian_metrics gnjm_checker u_gnjm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
